### hdl/alh_pkg.sv
// Package for the LCT/ALC header parser: phase type, status codes, field widths.
// No dependencies.
`timescale 1ns / 1ps
package alh_pkg;

    localparam int MaxHeaderWords = 255;

    typedef enum logic [2:0] {
        PH_IDLE, PH_FIXED, PH_HET, PH_HEL, PH_BODY, PH_SKIP
    } t_phase;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_SHORT    = 4'd1;
    localparam logic [3:0] ST_VERSION  = 4'd2;
    localparam logic [3:0] ST_CCI      = 4'd3;
    localparam logic [3:0] ST_NO_TSI   = 4'd4;
    localparam logic [3:0] ST_NO_TOI   = 4'd5;
    localparam logic [3:0] ST_TOI_LONG = 4'd6;
    localparam logic [3:0] ST_CODEPT   = 4'd7;
    localparam logic [3:0] ST_FTI_LEN  = 4'd8;
    localparam logic [3:0] ST_FLUTE    = 4'd9;

    localparam logic [7:0] HET_FTI  = 8'd64;
    localparam logic [7:0] HET_FDT  = 8'd192;
    localparam logic [7:0] HET_CENC = 8'd193;

    typedef struct packed {
        logic [3:0]  status;
        logic [47:0] session_id;
        logic [63:0] object_id;
        logic        close_session;
        logic        fdt_present;
        logic [19:0] fdt_instance;
        logic [47:0] xfer_length;
        logic [15:0] symbol_length;
        logic [31:0] max_block_length;
        logic [1:0]  content_coding;
        logic [9:0]  header_bytes;
    } t_result;

endpackage

### hdl/alh_core.sv
// Per-byte parse state and result formation for the LCT/ALC header parser.
// Depends on alh_pkg.
`timescale 1ns / 1ps
module alh_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_first,
    input  logic              i_last,
    output logic              o_emit,
    output alh_pkg::t_result  o_result
);
    import alh_pkg::*;

    logic [9:0]  r_pos, n_pos;
    t_phase      r_phase, n_phase;
    logic [31:0] r_w0, n_w0;
    logic [63:0] r_shift, n_shift;
    logic [9:0]  r_rem, n_rem;
    logic [7:0]  r_etype, n_etype;
    logic [9:0]  r_left, n_left;
    logic [47:0] r_tsi, n_tsi;
    logic [63:0] r_toi, n_toi;
    logic [20:0] r_fdt, n_fdt;
    logic [47:0] r_tlen, n_tlen;
    logic [15:0] r_slen, n_slen;
    logic [31:0] r_mbl, n_mbl;
    logic [1:0]  r_cenc, n_cenc;

    always_comb begin
        logic       s, h, a, run, fin, lastv;
        logic [1:0] o;
        logic [3:0] st;
        logic [3:0] fw;
        logic [4:0] tsil, toil;
        logic [7:0] hw;
        logic [9:0] idx, lft;
        logic [63:0] fs;
        logic [31:0] w0;
        t_phase      ph;
        n_pos = r_pos; n_phase = r_phase; n_w0 = r_w0; n_shift = r_shift;
        n_rem = r_rem; n_etype = r_etype; n_left = r_left; n_tsi = r_tsi;
        n_toi = r_toi; n_fdt = r_fdt; n_tlen = r_tlen; n_slen = r_slen;
        n_mbl = r_mbl; n_cenc = r_cenc;
        s = 1'b0; o = 2'd0; h = 1'b0; a = 1'b0; fw = 4'd0; hw = 8'd0;
        tsil = '0; toil = '0; idx = '0; lft = '0; fs = '0;
        fin = 1'b0; st = ST_OK; run = 1'b0;
        lastv = i_last;
        w0 = r_w0; ph = r_phase;
        if (i_valid) begin
            if (i_first) begin
                run = 1'b1; ph = PH_FIXED; w0 = '0;
                n_pos = '0; n_w0 = '0; n_shift = '0; n_rem = '0; n_etype = '0;
                n_left = '0; n_tsi = '0; n_toi = '0; n_fdt = '0; n_tlen = '0;
                n_slen = '0; n_mbl = '0; n_cenc = '0;
            end else if (r_phase == PH_SKIP) begin
                if (i_last) n_phase = PH_IDLE;
            end else if (r_phase != PH_IDLE) begin
                run = 1'b1;
            end
        end
        if (run) begin
            n_phase = ph;
            s = w0[23]; o = w0[22:21]; h = w0[20];
            fw = 4'd2 + {3'd0, s} + {2'd0, o} + {3'd0, h};
            if (i_first) begin
                n_pos = '0;
            end
            case (ph)
                PH_FIXED: begin
                    if (i_first || r_pos < 10'd4) n_w0 = {w0[23:0], i_byte};
                    if (i_first || r_pos == 10'd0) begin
                        if (i_byte[7:4] != 4'd1) begin
                            fin = 1'b1; st = ST_VERSION;
                        end else if (i_byte[3:2] != 2'd0) begin
                            fin = 1'b1; st = ST_CCI;
                        end
                    end else if (r_pos == 10'd1) begin
                        a = i_byte[1];
                        if (!i_byte[4] && !i_byte[7]) begin
                            fin = 1'b1; st = ST_NO_TSI;
                        end else if (!a && !i_byte[4] && i_byte[6:5] == 2'd0) begin
                            fin = 1'b1; st = ST_NO_TOI;
                        end else if (i_byte[6:5] == 2'd3 ||
                                     (i_byte[6:5] == 2'd2 && i_byte[4])) begin
                            fin = 1'b1; st = ST_TOI_LONG;
                        end
                    end else if (r_pos == 10'd3) begin
                        hw = w0[7:0];
                        if (i_byte != 8'd0) begin
                            fin = 1'b1; st = ST_CODEPT;
                        end else if ({4'd0, hw} < {4'd0, fw} ||
                                     32'(hw) > 32'(MaxHeaderWords)) begin
                            fin = 1'b1; st = ST_SHORT;
                        end else begin
                            n_rem = {hw, 2'b00} - 10'd4;
                        end
                    end else if (r_pos >= 10'd8) begin
                        tsil = {1'b0, s, 2'b00} + {3'd0, h, 1'b0};
                        toil = {o, 2'b00} + {3'd0, h, 1'b0};
                        if (r_pos < 10'd8 + 10'(tsil))
                            n_tsi = {r_tsi[39:0], i_byte};
                        else if (r_pos < 10'd8 + 10'(tsil) + 10'(toil))
                            n_toi = {r_toi[55:0], i_byte};
                    end
                end
                PH_HET: begin
                    n_etype = i_byte; n_shift = '0;
                    if (i_byte < 8'd128) n_phase = PH_HEL;
                    else begin
                        n_left = 10'd3; n_phase = PH_BODY;
                    end
                end
                PH_HEL: begin
                    if (r_etype == HET_FTI && i_byte != 8'd4) begin
                        fin = 1'b1; st = ST_FTI_LEN;
                    end else begin
                        n_left = (i_byte == 8'd0) ? 10'd2 : {i_byte, 2'b00} - 10'd2;
                        n_phase = PH_BODY;
                    end
                end
                default: begin
                    fs = {r_shift[55:0], i_byte};
                    n_shift = fs;
                    if (r_etype == HET_FDT && r_left == 10'd3 && i_byte[7:4] > 4'd2) begin
                        fin = 1'b1; st = ST_FLUTE;
                    end else begin
                        if (r_etype == HET_CENC && r_left == 10'd3 && i_byte <= 8'd3)
                            n_cenc = i_byte[1:0];
                        if (r_etype == HET_FTI) begin
                            idx = 10'd16 - r_left;
                            if (idx == 10'd7) n_tlen = fs[47:0];
                            else if (idx == 10'd11) n_slen = fs[15:0];
                            else if (idx == 10'd15) n_mbl = fs[31:0];
                        end
                        lft = r_left - 10'd1;
                        n_left = lft;
                        if (lft == 10'd0) begin
                            if (r_etype == HET_FDT) n_fdt = {1'b1, fs[19:0]};
                            n_phase = PH_HET;
                        end
                    end
                end
            endcase
            if (!fin) begin
                n_pos = (i_first ? 10'd0 : r_pos) + 10'd1;
                if (!i_first && r_pos > 10'd3) begin
                    n_rem = r_rem - 10'd1;
                    if (n_rem == 10'd0) begin
                        fin = 1'b1; st = ST_OK;
                    end else if (n_phase == PH_FIXED &&
                                 r_pos + 10'd1 == {4'd0, fw, 2'b00}) begin
                        n_phase = PH_HET;
                    end
                end
                if (!fin && i_last) begin
                    fin = 1'b1; st = ST_SHORT;
                end
            end
            if (fin) n_phase = lastv ? PH_IDLE : PH_SKIP;
        end
        o_emit = fin;
        o_result = '0;
        o_result.status = st;
        if (st == ST_OK) begin
            o_result.session_id       = n_tsi;
            o_result.object_id        = n_toi;
            o_result.close_session    = n_w0[17];
            o_result.fdt_present      = n_fdt[20];
            o_result.fdt_instance     = n_fdt[19:0];
            o_result.xfer_length      = n_tlen;
            o_result.symbol_length    = n_slen;
            o_result.max_block_length = n_mbl;
            o_result.content_coding   = n_cenc;
            o_result.header_bytes     = {n_w0[15:8], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos <= '0; r_w0 <= '0; r_shift <= '0; r_rem <= '0; r_etype <= '0;
            r_left <= '0; r_tsi <= '0; r_toi <= '0; r_fdt <= '0; r_tlen <= '0;
            r_slen <= '0; r_mbl <= '0; r_cenc <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos <= n_pos; r_w0 <= n_w0; r_shift <= n_shift; r_rem <= n_rem;
            r_etype <= n_etype; r_left <= n_left; r_tsi <= n_tsi; r_toi <= n_toi;
            r_fdt <= n_fdt; r_tlen <= n_tlen; r_slen <= n_slen; r_mbl <= n_mbl;
            r_cenc <= n_cenc;
        end
    end
endmodule

### hdl/alc_lct_header_parser.sv
// Top level of the LCT/ALC header parser: input register, parse core, output skid.
// Depends on alh_pkg and alh_core.
// Result path: the byte that ends the header passes the input register, then the
// core into the output register (or into the skid while the output is stalled).
// Throughput: one byte per cycle; s_axis_tready drops while the skid holds a
// result, or while the output is stalled and a result is forming.
// Reset: synchronous, active low; parse phase idle, no result pending.
`timescale 1ns / 1ps
module alc_lct_header_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // data_byte
    input  logic         s_axis_tuser,  // first_byte
    input  logic         s_axis_tlast,  // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, session_id, object_id, close_session, fdt_present, fdt_instance,
    // xfer_length, symbol_length, max_block_length, content_coding,
    // header_bytes, zero fill to 248 bits
    output logic [247:0] m_axis_tdata
);
    import alh_pkg::*;

    logic        r_in_v;
    logic [7:0]  r_in_b;
    logic        r_in_f, r_in_l;
    logic        w_emit;
    t_result     w_res;
    logic        r_out_v, r_skid_v;
    logic [245:0] r_out_d, r_skid_d;
    logic [245:0] w_pack;

    // accept only if the beat's possible result is sure to find a free slot
    assign s_axis_tready = !r_skid_v && !(r_out_v && !m_axis_tready && w_emit);

    alh_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_v),
        .i_byte   (r_in_b),
        .i_first  (r_in_f),
        .i_last   (r_in_l),
        .o_emit   (w_emit),
        .o_result (w_res)
    );

    assign w_pack = {w_res.header_bytes, w_res.content_coding, w_res.max_block_length,
                     w_res.symbol_length, w_res.xfer_length, w_res.fdt_instance,
                     w_res.fdt_present, w_res.close_session, w_res.object_id,
                     w_res.session_id, w_res.status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0; r_out_v <= 1'b0; r_skid_v <= 1'b0;
        end else begin
            r_in_v <= s_axis_tvalid && s_axis_tready;
            if (!r_out_v || m_axis_tready) begin
                if (r_skid_v) begin
                    r_out_v <= 1'b1; r_out_d <= r_skid_d;
                    r_skid_v <= 1'b0;
                    if (w_emit) begin
                        r_skid_v <= 1'b1; r_skid_d <= w_pack;
                    end
                end else begin
                    r_out_v <= w_emit; r_out_d <= w_pack;
                end
            end else if (w_emit) begin
                r_skid_v <= 1'b1; r_skid_d <= w_pack;
            end
        end
        r_in_b <= s_axis_tdata;
        r_in_f <= s_axis_tuser;
        r_in_l <= s_axis_tlast;
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {2'b00, r_out_d};
endmodule
